>>> rtl/cdpc_pkg.sv
package cdpc_pkg;

	localparam int GRAY_W = 8;
	localparam int ROW_W  = 9;
	localparam int COL_W  = 10;
	localparam int SUM_W  = 18;
	localparam int CNT_W  = 10;

	localparam logic [GRAY_W-1:0] THRESHOLD_RESET = 8'd100;
	localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

	// one finished column waiting for the divider
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [SUM_W-1:0] row_sum;
		logic [CNT_W-1:0] dark_count;
	} col_acc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/cdpc_ifs.sv
interface pixel_if import cdpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GRAY_W-1:0] gray_value;
	logic [ROW_W-1:0]  row_index;
	logic [COL_W-1:0]  column_index;
	logic              column_end;

	modport source (output valid, gray_value, row_index, column_index, column_end,
		input ready);
	modport sink (input valid, gray_value, row_index, column_index, column_end,
		output ready);
endinterface

interface centroid_if import cdpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] result_column;
	logic [ROW_W-1:0] mean_row;

	modport source (output valid, result_column, mean_row, input ready);
	modport sink (input valid, result_column, mean_row, output ready);
endinterface

>>> rtl/cdpc_front.sv
module cdpc_front import cdpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [GRAY_W-1:0] cfg_wr_data,
	pixel_if.sink             pixel,
	input  q_status_t         q_status,
	output logic              push,
	output col_acc_t          push_entry
);

	logic [GRAY_W-1:0] thr_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;

	logic             accept;
	logic             dark;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] cnt_next;

	assign pixel.ready = !q_status.full;

	always_comb begin
		accept   = pixel.valid && pixel.ready;
		dark     = pixel.gray_value <= thr_q;
		sum_add  = {1'b0, sum_q} + (dark ? (SUM_W+1)'(pixel.row_index) : '0);
		sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
		cnt_next = (dark && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		// the ending pixel is counted before the column is closed
		push       = accept && pixel.column_end && cnt_next != '0;
		push_entry = '{column: pixel.column_index, row_sum: sum_next, dark_count: cnt_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (accept) begin
				if (pixel.column_end) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

endmodule

>>> rtl/cdpc_queue.sv
module cdpc_queue import cdpc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  col_acc_t  push_entry,
	input  logic      pop,
	output col_acc_t  pop_entry,
	output q_status_t status
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	col_acc_t          entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = fill_q == FILL_W'(DEPTH);
	assign status.empty = fill_q == '0;
	assign pop_entry    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/cdpc_back.sv
module cdpc_back import cdpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	input  col_acc_t  pop_entry,
	output logic      pop,
	centroid_if.source centroid
);

	localparam int IT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} div_state_t;

	div_state_t       state_q;
	logic [IT_W-1:0]  iter_q;
	logic [COL_W-1:0] col_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_mean_q;

	logic [CNT_W:0]   rem_shift;
	logic [CNT_W:0]   rem_diff;
	logic             ge;
	logic [CNT_W-1:0] rem_next;
	logic             out_free;

	always_comb begin
		// restoring division, one quotient bit per cycle, MSB first
		rem_shift = {rem_q, quo_q[SUM_W-1]};
		rem_diff  = rem_shift - {1'b0, div_q};
		ge        = rem_shift >= {1'b0, div_q};
		rem_next  = ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
		out_free  = !out_valid_q || centroid.ready;
		pop       = (state_q == ST_IDLE) && !q_status.empty;
	end

	assign centroid.valid         = out_valid_q;
	assign centroid.result_column = out_col_q;
	assign centroid.mean_row      = out_mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						iter_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == IT_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (centroid.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_q <= pop_entry.column;
			quo_q <= pop_entry.row_sum;
			div_q <= pop_entry.dark_count;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
		if (state_q == ST_DONE && out_free) begin
			out_col_q  <= col_q;
			out_mean_q <= quo_q[ROW_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != '0)
		else $error("divider started on an empty column");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	a_mean_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> quo_q[SUM_W-1:ROW_W] == '0)
		else $error("mean row exceeds row range");
`endif

endmodule

>>> rtl/column_dark_pixel_centroid.sv
// Dark-pixel centroid per column. Pixels arrive in column-major order and are
// accepted one per cycle while the queue is not full; each pixel at or below the
// threshold written through cfg_wr_data adds its row to a saturating sum and
// count. The pixel flagged column_end closes the column: if it held any dark
// pixel, the column is queued (QUEUE_DEPTH entries) for a shift-subtract divider
// that produces one quotient bit per cycle; each reported column passes through
// the divider as a load, 18 bit steps and a handoff to the output register.
// Pixel input stalls only while the queue is full, which happens when columns
// with a dark pixel close faster than the divider drains them, or when the
// result side holds off long enough to back up the output register, the
// divider and the queue. Columns with no dark pixel produce no result.
module column_dark_pixel_centroid import cdpc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [GRAY_W-1:0] cfg_wr_data,
	pixel_if.sink             pixel,
	centroid_if.source        centroid
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	col_acc_t  push_entry;
	col_acc_t  pop_entry;

	cdpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pixel       (pixel),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	cdpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	cdpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_entry (pop_entry),
		.pop       (pop),
		.centroid  (centroid)
	);

endmodule
